// File: src/deq_pkg.sv
`default_nettype none

package deq_pkg;

	localparam int DEFAULT_CAPACITY = 16;
	localparam int DATA_W           = 32;
	localparam int OP_W             = 3;
	localparam int STATUS_W         = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_DUMP       = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

`default_nettype wire

// File: src/double_ended_queue.sv
`default_nettype none

// Double-ended queue of 32-bit signed values in a ring buffer of CAPACITY entries.
//
// Command channel: an operation (push back, push front, pop back, pop front,
// dump) is taken at a rising edge with start high and busy low; value_in is
// used by pushes only.
// Result channel: each result is shown for one cycle with strobe high, carrying
// status, value_out, occupancy and last. The receiver cannot stall it.
//
// Every operation gives its first result in the cycle after it is taken.
// Pushes and pops keep busy low and can be issued every cycle. A dump of N
// elements reads the store once per cycle, holds busy while further elements
// remain to be read and gives N results on consecutive cycles; the single
// store read port sets that rate. Push into a full queue reports full, pop
// or dump of an empty queue reports empty, both leaving the contents untouched.
// Reset empties the queue at once; the stored values are not cleared, and no
// result is produced during or straight after reset.

module double_ended_queue
	import deq_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY,
	parameter int IDX_W    = $clog2(CAPACITY),
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [OP_W-1:0]          operation,
	input  wire logic signed [DATA_W-1:0] value_in,
	output logic                          strobe,
	output logic [STATUS_W-1:0]           status,
	output logic signed [DATA_W-1:0]      value_out,
	output logic [CNT_W-1:0]              occupancy,
	output logic                          last
);

	logic                     mem_we;
	logic [IDX_W-1:0]         mem_waddr;
	logic signed [DATA_W-1:0] mem_wdata;
	logic                     mem_re;
	logic [IDX_W-1:0]         mem_raddr;
	logic signed [DATA_W-1:0] mem_rdata;

	deq_ctrl #(
		.CAPACITY (CAPACITY),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.value_in  (value_in),
		.strobe    (strobe),
		.status    (status),
		.value_out (value_out),
		.occupancy (occupancy),
		.last      (last),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	deq_mem #(
		.DEPTH  (CAPACITY),
		.ADDR_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

// File: src/deq_mem.sv
`default_nettype none

module deq_mem
	import deq_pkg::*;
#(
	parameter int DEPTH  = DEFAULT_CAPACITY,
	parameter int ADDR_W = $clog2(DEFAULT_CAPACITY)
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [ADDR_W-1:0]        waddr,
	input  wire logic signed [DATA_W-1:0] wdata,
	input  wire logic                     re,
	input  wire logic [ADDR_W-1:0]        raddr,
	output logic signed [DATA_W-1:0]      rdata
);

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data between reads
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: src/deq_ctrl.sv
`default_nettype none

module deq_ctrl
	import deq_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY,
	parameter int IDX_W    = $clog2(DEFAULT_CAPACITY),
	parameter int CNT_W    = $clog2(DEFAULT_CAPACITY + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [OP_W-1:0]          operation,
	input  wire logic signed [DATA_W-1:0] value_in,
	output logic                          strobe,
	output logic [STATUS_W-1:0]           status,
	output logic signed [DATA_W-1:0]      value_out,
	output logic [CNT_W-1:0]              occupancy,
	output logic                          last,
	// memory port
	output logic                          mem_we,
	output logic [IDX_W-1:0]              mem_waddr,
	output logic signed [DATA_W-1:0]      mem_wdata,
	output logic                          mem_re,
	output logic [IDX_W-1:0]              mem_raddr,
	input  wire logic signed [DATA_W-1:0] mem_rdata
);

	localparam int SUM_W = IDX_W + 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DUMP = 3'b010,
		S_SPARE = 3'b100
	} state_t;

	state_t                 state_q;
	logic [IDX_W-1:0]       front_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       dump_ptr_q;
	logic [CNT_W-1:0]       dump_left_q;
	logic                   strobe_q;
	status_t                status_q;
	logic [CNT_W-1:0]       occ_q;
	logic                   last_q;
	logic                   from_mem_q;

	op_t                    op;
	logic                   accept;
	logic                   full;
	logic                   empty;
	logic [IDX_W-1:0]       front_inc;
	logic [IDX_W-1:0]       front_dec;
	logic [IDX_W-1:0]       dump_inc;
	logic [SUM_W-1:0]       back_sum;
	logic [SUM_W-1:0]       tail_sum;
	logic [IDX_W-1:0]       back_slot;
	logic [IDX_W-1:0]       tail_slot;

	function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= SUM_W'(CAPACITY)) ? s - SUM_W'(CAPACITY) : s;
		return r[IDX_W-1:0];
	endfunction

	assign op     = op_t'(operation);
	assign busy   = (state_q != S_IDLE);
	assign accept = start && (state_q == S_IDLE);
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);

	assign front_inc = (front_q == IDX_W'(CAPACITY - 1)) ? '0 : front_q + 1'b1;
	assign front_dec = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - 1'b1;
	assign dump_inc  = (dump_ptr_q == IDX_W'(CAPACITY - 1)) ? '0 : dump_ptr_q + 1'b1;

	// first free slot behind the back, and the back element itself
	assign back_sum  = SUM_W'(front_q) + SUM_W'(count_q);
	assign tail_sum  = back_sum - 1'b1;
	assign back_slot = wrap_idx(back_sum);
	assign tail_slot = wrap_idx(tail_sum);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = back_slot;
		mem_wdata = value_in;
		mem_re    = 1'b0;
		mem_raddr = front_q;
		if (accept) begin
			unique case (op)
				OP_PUSH_BACK: begin
					mem_we = !full;
				end
				OP_PUSH_FRONT: begin
					mem_we    = !full;
					mem_waddr = front_dec;
				end
				OP_POP_BACK: begin
					mem_re    = !empty;
					mem_raddr = tail_slot;
				end
				OP_POP_FRONT, OP_DUMP: begin
					mem_re = !empty;
				end
				default: begin
				end
			endcase
		end else if (state_q == S_DUMP) begin
			mem_re    = 1'b1;
			mem_raddr = dump_ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			dump_ptr_q  <= '0;
			dump_left_q <= '0;
			strobe_q    <= 1'b0;
			status_q    <= ST_OK;
			occ_q       <= '0;
			last_q      <= 1'b0;
			from_mem_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						strobe_q   <= 1'b1;
						status_q   <= ST_OK;
						occ_q      <= count_q;
						last_q     <= 1'b1;
						from_mem_q <= 1'b0;
						unique case (op)
							OP_PUSH_BACK, OP_PUSH_FRONT: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + 1'b1;
									occ_q   <= count_q + 1'b1;
									if (op == OP_PUSH_FRONT) begin
										front_q <= front_dec;
									end
								end
							end
							OP_POP_BACK, OP_POP_FRONT: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									count_q    <= count_q - 1'b1;
									occ_q      <= count_q - 1'b1;
									from_mem_q <= 1'b1;
									if (op == OP_POP_FRONT) begin
										front_q <= front_inc;
									end
								end
							end
							OP_DUMP: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									from_mem_q  <= 1'b1;
									dump_ptr_q  <= front_inc;
									dump_left_q <= count_q - 1'b1;
									last_q      <= (count_q == CNT_W'(1));
									if (count_q != CNT_W'(1)) begin
										state_q <= S_DUMP;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DUMP: begin
					// one read per cycle; each result shows the cycle after its read
					strobe_q    <= 1'b1;
					status_q    <= ST_OK;
					occ_q       <= count_q;
					from_mem_q  <= 1'b1;
					dump_ptr_q  <= dump_inc;
					dump_left_q <= dump_left_q - 1'b1;
					last_q      <= (dump_left_q == CNT_W'(1));
					if (dump_left_q == CNT_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign strobe    = strobe_q;
	assign status    = status_q;
	assign value_out = from_mem_q ? mem_rdata : '0;
	assign occupancy = occ_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// File: src/deq_checker.sv
`default_nettype none

module deq_checker
	import deq_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     start,
	input wire logic                     busy,
	input wire logic [STATUS_W-1:0]      status,
	input wire logic [CNT_W-1:0]         occupancy,
	input wire logic                     strobe,
	input wire logic                     last
);

	// every transaction taken answers in the next cycle
	a_answer_next: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> strobe)
		else $error("no result after accepted transaction");

	// a result that is not the final one only comes out of a running dump
	a_more_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("non-final result while idle");

	// end of a dump shows its final element
	a_dump_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && last))
		else $error("dump ended without final result");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == ST_FULL) |-> (occupancy == CNT_W'(CAPACITY)))
		else $error("full status with spare room");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == ST_EMPTY) |-> (occupancy == '0 && last))
		else $error("empty status on non-empty queue");

endmodule

bind double_ended_queue deq_checker #(
	.CAPACITY (CAPACITY),
	.CNT_W    (CNT_W)
) u_deq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.status    (status),
	.occupancy (occupancy),
	.strobe    (strobe),
	.last      (last)
);

`default_nettype wire
